[sv/gfdg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfdg_pkg
// Shared widths, register indexes and control types of the forward-difference
// gradient block.
// ----------------------------------------------------------------------------
package gfdg_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int DIFF_W     = 33;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_ADDR_W = 2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [DIFF_W-1:0]   diff_t;
  typedef logic [CFG_DATA_W-1:0]      cfg_data_t;
  typedef logic [CFG_ADDR_W-1:0]      cfg_addr_t;

  localparam cfg_addr_t CFG_ROW_LENGTH     = cfg_addr_t'(0);
  localparam cfg_addr_t CFG_ROWS_PER_PLANE = cfg_addr_t'(1);

  // per-item control from the pointer logic to the difference stage
  typedef struct packed {
    logic produce;
    logic col_is_newest;
  } tap_ctl_t;

endpackage
`default_nettype wire

[sv/gfdg_sample_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfdg_sample_if
// Valid/ready channel carrying one grid sample per item.
// ----------------------------------------------------------------------------
interface gfdg_sample_if;
  import gfdg_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    start_volume;

  modport source (output valid, output sample, output start_volume, input ready);
  modport sink   (input valid, input sample, input start_volume, output ready);

endinterface
`default_nettype wire

[sv/gfdg_grad_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfdg_grad_if
// Valid/ready channel carrying the three forward differences of one sample.
// ----------------------------------------------------------------------------
interface gfdg_grad_if;
  import gfdg_pkg::*;

  logic  valid;
  logic  ready;
  diff_t diff_along_row;
  diff_t diff_along_column;
  diff_t diff_along_depth;

  modport source (output valid, output diff_along_row, output diff_along_column,
                  output diff_along_depth, input ready);
  modport sink   (input valid, input diff_along_row, input diff_along_column,
                  input diff_along_depth, output ready);

endinterface
`default_nettype wire

[sv/grid_forward_difference_gradient.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grid_forward_difference_gradient
// Forward differences along row, column and depth over a streamed 3D grid.
// ----------------------------------------------------------------------------
// the accepting edge reads the taps and loads the tap stage; the output register
// takes the differences when free; back-to-back items give one result per cycle
// throughput: 1 sample per cycle; an output stall holds one item in the tap
// stage and then drops samples.ready until the output is taken
// results start after one plane plus one sample of the current grid
// reset clears pointer, plane-full flag and geometry (64 x 64); store not cleared
module grid_forward_difference_gradient #(
  parameter int MAX_ROW_LENGTH     = 64,
  parameter int MAX_ROWS_PER_PLANE = 64
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire gfdg_pkg::cfg_addr_t cfg_addr,
  input  wire gfdg_pkg::cfg_data_t cfg_wdata,
  gfdg_sample_if.sink              samples,
  gfdg_grad_if.source              gradients
);
  import gfdg_pkg::*;

  localparam int DEPTH = MAX_ROW_LENGTH * MAX_ROWS_PER_PLANE;
  localparam int AW    = $clog2(DEPTH);

  logic          accept;
  logic          can_load;
  logic          held;
  logic [AW-1:0] wr_addr, row_addr, col_addr;
  tap_ctl_t      ctl;
  sample_t       centre, row_val, col_val;

  assign samples.ready = can_load;
  assign accept        = samples.valid && can_load;

  gfdg_ctrl #(
    .MAX_ROW_LENGTH    (MAX_ROW_LENGTH),
    .MAX_ROWS_PER_PLANE(MAX_ROWS_PER_PLANE),
    .DEPTH             (DEPTH),
    .AW                (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .start    (samples.start_volume),
    .accept   (accept),
    .wr_addr  (wr_addr),
    .row_addr (row_addr),
    .col_addr (col_addr),
    .ctl      (ctl)
  );

  // one copy of the plane per tap so each has its own read port
  gfdg_tap_ram #(.DEPTH(DEPTH), .AW(AW), .DW(SAMPLE_W)) u_centre_ram (
    .clk(clk), .we(accept), .waddr(wr_addr), .wdata(samples.sample),
    .re(accept), .raddr(wr_addr), .rdata(centre)
  );

  gfdg_tap_ram #(.DEPTH(DEPTH), .AW(AW), .DW(SAMPLE_W)) u_row_ram (
    .clk(clk), .we(accept), .waddr(wr_addr), .wdata(samples.sample),
    .re(accept), .raddr(row_addr), .rdata(row_val)
  );

  gfdg_tap_ram #(.DEPTH(DEPTH), .AW(AW), .DW(SAMPLE_W)) u_col_ram (
    .clk(clk), .we(accept), .waddr(wr_addr), .wdata(samples.sample),
    .re(accept), .raddr(col_addr), .rdata(col_val)
  );

  gfdg_diff u_diff (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && ctl.produce),
    .ctl      (ctl),
    .sample_in(samples.sample),
    .centre   (centre),
    .row_val  (row_val),
    .col_val  (col_val),
    .can_load (can_load),
    .held     (held),
    .gradients(gradients)
  );

`ifndef SYNTHESIS
  // a held item with a stalled output blocks new samples
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    held && gradients.valid && !gradients.ready |-> !samples.ready)
    else $error("sample taken while tap stage and output are both full");

  // a geometry write restarts filling, so no result is due right after
  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_we && (cfg_addr == CFG_ROW_LENGTH || cfg_addr == CFG_ROWS_PER_PLANE)
    |=> !ctl.produce)
    else $error("result possible right after a geometry write");

  // the row neighbour is never the entry being overwritten
  a_row_tap_distinct: assert property (@(posedge clk) disable iff (rst)
    accept |-> row_addr != wr_addr)
    else $error("row tap address equals write address");

  // a start item never yields a result of its own
  a_start_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && samples.start_volume |=> !held || $past(held && !can_load))
    else $error("start item produced a result");
`endif

endmodule
`default_nettype wire

[sv/gfdg_tap_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfdg_tap_ram
// Single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module gfdg_tap_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // read returns the old contents on an address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule
`default_nettype wire

[sv/gfdg_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfdg_ctrl
// Grid geometry registers, circular write pointer, plane-full flag and the
// store addresses of the centre, row and column taps.
// ----------------------------------------------------------------------------
module gfdg_ctrl #(
  parameter int MAX_ROW_LENGTH     = 64,
  parameter int MAX_ROWS_PER_PLANE = 64,
  parameter int DEPTH              = MAX_ROW_LENGTH * MAX_ROWS_PER_PLANE,
  parameter int AW                 = $clog2(DEPTH)
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire gfdg_pkg::cfg_addr_t cfg_addr,
  input  wire gfdg_pkg::cfg_data_t cfg_wdata,
  input  wire logic                start,
  input  wire logic                accept,
  output logic [AW-1:0]            wr_addr,
  output logic [AW-1:0]            row_addr,
  output logic [AW-1:0]            col_addr,
  output gfdg_pkg::tap_ctl_t       ctl
);
  import gfdg_pkg::*;

  localparam int WW    = $clog2(MAX_ROW_LENGTH + 1);
  localparam int HW    = $clog2(MAX_ROWS_PER_PLANE + 1);
  localparam int PW    = $clog2(DEPTH + 1);
  localparam int RST_W = (64 > MAX_ROW_LENGTH) ? MAX_ROW_LENGTH : 64;
  localparam int RST_H = (64 > MAX_ROWS_PER_PLANE) ? MAX_ROWS_PER_PLANE : 64;

  logic [WW-1:0] row_len;
  logic [HW-1:0] rows;
  logic [PW-1:0] plane;
  logic [AW-1:0] wp;
  logic          full;

  logic          wr_row, wr_rows;
  logic [WW-1:0] row_len_wr, row_len_next;
  logic [HW-1:0] rows_wr, rows_next;
  logic [PW-1:0] plane_next;
  logic [PW-1:0] wp_cur, row_sum, row_wrap;
  logic [PW:0]   col_sum;
  logic          full_cur;

  assign wr_row  = cfg_we && (cfg_addr == CFG_ROW_LENGTH);
  assign wr_rows = cfg_we && (cfg_addr == CFG_ROWS_PER_PLANE);

  // clamp written geometry into the supported range
  always_comb begin
    if (cfg_wdata < cfg_data_t'(2)) begin
      row_len_wr = WW'(2);
    end else if (32'(cfg_wdata) > MAX_ROW_LENGTH) begin
      row_len_wr = WW'(MAX_ROW_LENGTH);
    end else begin
      row_len_wr = WW'(cfg_wdata);
    end
    if (cfg_wdata == '0) begin
      rows_wr = HW'(1);
    end else if (32'(cfg_wdata) > MAX_ROWS_PER_PLANE) begin
      rows_wr = HW'(MAX_ROWS_PER_PLANE);
    end else begin
      rows_wr = HW'(cfg_wdata);
    end
    row_len_next = wr_row ? row_len_wr : row_len;
    rows_next    = wr_rows ? rows_wr : rows;
    plane_next   = PW'(PW'(row_len_next) * PW'(rows_next));
  end

  // pointer arithmetic: wp < plane and row_len < plane when the column tap is used
  always_comb begin
    wp_cur   = start ? '0 : PW'(wp);
    full_cur = start ? 1'b0 : full;
    row_sum  = wp_cur + PW'(1);
    row_wrap = (row_sum == plane) ? '0 : row_sum;
    col_sum  = (PW+1)'(wp_cur) + (PW+1)'(row_len);
    if (col_sum >= (PW+1)'(plane)) begin
      col_sum = col_sum - (PW+1)'(plane);
    end
  end

  assign wr_addr           = AW'(wp_cur);
  assign row_addr          = AW'(row_wrap);
  assign col_addr          = AW'(col_sum);
  assign ctl.produce       = full_cur;
  assign ctl.col_is_newest = (rows == HW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      row_len <= WW'(RST_W);
      rows    <= HW'(RST_H);
      plane   <= PW'(RST_W * RST_H);
      wp      <= '0;
      full    <= 1'b0;
    end else if (wr_row || wr_rows) begin
      row_len <= row_len_next;
      rows    <= rows_next;
      plane   <= plane_next;
      wp      <= '0;
      full    <= 1'b0;
    end else if (accept) begin
      wp   <= AW'(row_wrap);
      full <= full_cur || (row_sum == plane);
    end
  end

endmodule
`default_nettype wire

[sv/gfdg_diff.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gfdg_diff
// Holds an item while its taps are read, then forms the three differences
// into the output register.
// ----------------------------------------------------------------------------
module gfdg_diff (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire gfdg_pkg::tap_ctl_t ctl,
  input  wire gfdg_pkg::sample_t  sample_in,
  input  wire gfdg_pkg::sample_t  centre,
  input  wire gfdg_pkg::sample_t  row_val,
  input  wire gfdg_pkg::sample_t  col_val,
  output logic                    can_load,
  output logic                    held,
  gfdg_grad_if.source             gradients
);
  import gfdg_pkg::*;

  logic    tap_valid;
  sample_t tap_sample;
  logic    tap_col_new;
  logic    out_valid;
  logic    move;
  sample_t col_sel;
  diff_t   centre_x;

  assign move     = tap_valid && (!out_valid || gradients.ready);
  assign can_load = !tap_valid || move;
  assign held     = tap_valid;

  assign col_sel  = tap_col_new ? tap_sample : col_val;
  assign centre_x = {centre[SAMPLE_W-1], centre};

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        tap_valid <= 1'b1;
      end else if (move) begin
        tap_valid <= 1'b0;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (gradients.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tap_sample  <= sample_in;
      tap_col_new <= ctl.col_is_newest;
    end
    if (move) begin
      gradients.diff_along_row    <= {row_val[SAMPLE_W-1], row_val} - centre_x;
      gradients.diff_along_column <= {col_sel[SAMPLE_W-1], col_sel} - centre_x;
      gradients.diff_along_depth  <= {tap_sample[SAMPLE_W-1], tap_sample} - centre_x;
    end
  end

  assign gradients.valid = out_valid;

endmodule
`default_nettype wire

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stand-alone bench for the forward-difference gradient block: streams grids
// of Q16.16 samples under several plane geometries, with random idling on both
// channels, and checks every gradient item against an in-bench plane history.
// ----------------------------------------------------------------------------
module tb;
  import gfdg_pkg::*;

  localparam int MAX_ROW      = 64;
  localparam int MAX_ROWS     = 64;
  localparam int HISTORY_SIZE = MAX_ROW * MAX_ROWS;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 10;

  typedef struct packed {
    diff_t along_row;
    diff_t along_column;
    diff_t along_depth;
  } grad_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      cfg_we;
  cfg_addr_t cfg_addr;
  cfg_data_t cfg_wdata;

  gfdg_sample_if samples_ch ();
  gfdg_grad_if   grads_ch ();

  grid_forward_difference_gradient DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .samples   (samples_ch),
    .gradients (grads_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gradient prediction state
  sample_t     sample_history [HISTORY_SIZE];
  int unsigned wr_ptr;
  int unsigned fill_cnt;
  cfg_data_t   row_len_reg;
  cfg_data_t   rows_reg;
  grad_t       expected_grads [$];

  int unsigned samples_sent;
  int unsigned grads_checked;
  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          idling_on;
  int unsigned stall_left;

  function automatic int unsigned row_samples();
    int unsigned w;
    w = row_len_reg;
    if (w < 2) w = 2;
    if (w > MAX_ROW) w = MAX_ROW;
    return w;
  endfunction

  function automatic int unsigned rows_in_plane();
    int unsigned h;
    h = rows_reg;
    if (h < 1) h = 1;
    if (h > MAX_ROWS) h = MAX_ROWS;
    return h;
  endfunction

  function automatic diff_t forward_diff(sample_t ahead, sample_t centre);
    return $signed({ahead[31], ahead}) - $signed({centre[31], centre});
  endfunction

  function automatic void predict_gradient(sample_t s, logic st);
    int unsigned w;
    int unsigned plane;
    sample_t     centre;
    sample_t     right;
    sample_t     below;
    grad_t       g;
    w = row_samples();
    plane = w * rows_in_plane();
    if (st) begin
      wr_ptr = 0;
      fill_cnt = 0;
    end
    if (wr_ptr >= plane) wr_ptr = 0;
    if (fill_cnt >= plane) begin
      centre = sample_history[wr_ptr];
      right = sample_history[(wr_ptr + 1) % plane];
      // with one row per plane the column neighbour is the arriving sample
      below = (w >= plane) ? s : sample_history[(wr_ptr + w) % plane];
      g.along_row = forward_diff(right, centre);
      g.along_column = forward_diff(below, centre);
      g.along_depth = forward_diff(s, centre);
      expected_grads.push_back(g);
    end
    sample_history[wr_ptr] = s;
    wr_ptr = (wr_ptr + 1) % plane;
    if (fill_cnt < plane) fill_cnt++;
  endfunction

  function automatic void check_field(string name, diff_t want, diff_t got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endfunction

  // result checker
  always @(posedge clk) begin
    grad_t want;
    if (!rst && grads_ch.valid && grads_ch.ready) begin
      if (expected_grads.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected gradient item: row %0d col %0d depth %0d", $realtime,
                   grads_ch.diff_along_row, grads_ch.diff_along_column,
                   grads_ch.diff_along_depth);
      end else begin
        want = expected_grads.pop_front();
        check_field("diff_along_row", want.along_row, grads_ch.diff_along_row);
        check_field("diff_along_column", want.along_column, grads_ch.diff_along_column);
        check_field("diff_along_depth", want.along_depth, grads_ch.diff_along_depth);
        grads_checked++;
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst) begin
      grads_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left = stall_left - 1;
      grads_ch.ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 14) - 1;
      grads_ch.ready <= 1'b0;
    end else begin
      grads_ch.ready <= 1'b1;
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((samples_ch.valid && samples_ch.ready) || (grads_ch.valid && grads_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d gradient items outstanding",
               quiet_cycles, expected_grads.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_sample(sample_t s, logic st);
    samples_ch.valid <= 1'b1;
    samples_ch.sample <= s;
    samples_ch.start_volume <= st;
    do @(posedge clk); while (!samples_ch.ready);
    predict_gradient(s, st);
    samples_sent++;
  endtask

  task automatic sender_pause();
    if (idling_on && $urandom_range(0, 3) == 0) begin
      samples_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  // hold the sender until every predicted item has come out
  task automatic wait_results_done(int unsigned extra);
    samples_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_grads.size() != 0);
    repeat (extra) @(posedge clk);
  endtask

  task automatic set_geometry(cfg_data_t w, cfg_data_t h);
    wait_results_done(SETTLE);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_ROW_LENGTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr <= CFG_ROWS_PER_PLANE;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_len_reg = w;
    rows_reg = h;
    wr_ptr = 0;
    fill_cnt = 0;
  endtask

  function automatic sample_t pick_sample();
    sample_t v;
    case ($urandom_range(0, 9))
      0: v = 32'h7FFF_FFFF;
      1: v = 32'h8000_0000;
      2: v = 32'sd0;
      3, 4: begin
        v = $urandom_range(0, 262143);
        v = v - 131072;
      end
      default: v = $urandom();
    endcase
    return v;
  endfunction

  // at the reset geometry of 64 x 64 a few samples must give no result
  task automatic test_reset_geometry();
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'sd0, 1'b0);
    send_sample(-32'sd1, 1'b0);
    wait_results_done(SETTLE);
  endtask

  // largest positive and negative differences, with row and plane wrap
  task automatic test_field_extremes();
    sample_t vals [10];
    vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd0,
             -32'sd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'sd1};
    set_geometry(7'd3, 7'd2);
    foreach (vals[i]) begin
      sender_pause();
      send_sample(vals[i], i == 0);
    end
  endtask

  // out-of-range registers clamp to 2 x 1: one row per plane
  task automatic test_one_row_per_plane();
    set_geometry(7'd0, 7'd0);
    for (int i = 0; i < 6; i++) begin
      sender_pause();
      send_sample(pick_sample(), i == 0);
    end
  endtask

  // a start in the middle of a grid must suppress results until refilled
  task automatic test_restart_mid_grid();
    set_geometry(7'd2, 7'd1);
    for (int i = 0; i < 7; i++) begin
      sender_pause();
      send_sample(pick_sample(), i == 0 || i == 4);
    end
  endtask

  task automatic run_grids(cfg_data_t w, cfg_data_t h, int unsigned budget,
                           bit with_idling, bit hold_midway);
    int unsigned plane;
    int unsigned len;
    int unsigned sent;
    logic        st;
    set_geometry(w, h);
    idling_on = with_idling;
    plane = row_samples() * rows_in_plane();
    sent = 0;
    while (sent < budget) begin
      // grid plus at least one padding plane, at times cut to a random shorter length
      len = plane * 2 + $urandom_range(0, plane);
      if ($urandom_range(0, 7) == 0) len = $urandom_range(1, len);
      for (int unsigned k = 0; k < len && sent < budget; k++) begin
        st = (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 49) == 0);
        if (hold_midway && sent == budget / 2) wait_results_done(0);
        sender_pause();
        send_sample(pick_sample(), st);
        sent++;
      end
    end
  endtask

  task automatic test_random_grids();
    run_grids(7'd5, 7'd3, 100, 1'b1, 1'b1);
    run_grids(7'd127, 7'd1, 140, 1'b0, 1'b0);
    run_grids(7'd1, 7'd127, 180, 1'b1, 1'b0);
    run_grids(7'd4, 7'd4, 60, 1'b1, 1'b0);
    run_grids(7'd2, 7'd3, 40, 1'b0, 1'b0);
  endtask

  initial begin
    samples_ch.valid <= 1'b0;
    samples_ch.sample <= '0;
    samples_ch.start_volume <= 1'b0;
    cfg_we <= 1'b0;
    cfg_addr <= CFG_ROW_LENGTH;
    cfg_wdata <= '0;
    row_len_reg = 7'd64;
    rows_reg = 7'd64;
    wr_ptr = 0;
    fill_cnt = 0;
    samples_sent = 0;
    grads_checked = 0;
    mismatches = 0;
    quiet_cycles = 0;
    stall_left = 0;
    idling_on = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_geometry();
    test_field_extremes();
    test_one_row_per_plane();
    test_restart_mid_grid();
    test_random_grids();

    wait_results_done(SETTLE);
    $display("sent %0d samples over geometries 64x64, 3x2, 2x1, 5x3, 64x1, 2x64, 4x4, 2x3",
             samples_sent);
    $display("checked %0d gradient items, %0d mismatches", grads_checked, mismatches);
    if (mismatches == 0 && expected_grads.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[grid_forward_difference_gradient.f]
sv/gfdg_pkg.sv
sv/gfdg_sample_if.sv
sv/gfdg_grad_if.sv
sv/gfdg_tap_ram.sv
sv/gfdg_ctrl.sv
sv/gfdg_diff.sv
sv/grid_forward_difference_gradient.sv
dv/tb.sv
